// ----- sv/ookpc_pkg.sv -----
// Package for the OOK pulse code transmitter.
// Holds request kinds, phase codes, register indexes, field widths and the result type.
// No dependencies.
package ookpc_pkg;

    // Field widths fixed by the interface
    localparam int CODE_W      = 32;
    localparam int CODE_LEN_W  = 6;
    localparam int REP_W       = 16;
    localparam int TICKS_W     = 24;
    localparam int PULSE_W     = 16;
    localparam int UNITS_W     = 8;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Request kinds carried on tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Phase codes
    localparam logic [1:0] PH_BIT_HIGH  = 2'd0;
    localparam logic [1:0] PH_BIT_LOW   = 2'd1;
    localparam logic [1:0] PH_SYNC_HIGH = 2'd2;
    localparam logic [1:0] PH_SYNC_LOW  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_UNIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH_UNITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW_UNITS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH_UNITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW_UNITS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH_UNITS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW_UNITS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_OUTPUT   = 3'd7;

    // One result, line_level in the lowest bit
    typedef struct packed {
        logic start_rejected;
        logic done_res;
        logic busy_res;
        logic line_level;
    } result_t;

endpackage

// ----- sv/ook_pulse_code_transmitter.sv -----
// Top level of the OOK pulse code transmitter.
// Holds configuration, transmit state and the zero-phase skip logic.
// Depends on ookpc_pkg and ookpc_out_skid.

// The block takes one request per clock when the result buffer has room, ticks
// and starts alike, and gives one result per request through a two-entry output
// buffer. A start loads the code word, its length (saturated to MAX_BITS) and
// the repeat count; each tick request is one time unit and reports the line
// level for it. Bits go out most significant first as a high then a low phase,
// and each repeat ends with a sync symbol; phases of zero length are skipped
// within the same request by a search over the remaining word bits, and a
// phase's tick count is pulse_unit times its factor taken when the phase starts.
// The cycle time is set by that search, the factor select and the 16x8
// multiply that loads the phase counter. Configuration writes are taken at any
// time on their own channel.
module ook_pulse_code_transmitter #(
    parameter int MAX_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // tdata: code_value[31:0], code_length[37:32], repeat_count[53:38], zero pad
    input  logic [ookpc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // tuser: req_type
    input  logic                                   s_axis_tuser,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: line_level[0], busy_res[1], done_res[2], start_rejected[3], zero pad
    output logic [ookpc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ookpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ookpc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ookpc_pkg::*;

    localparam int CNT_W = $clog2(MAX_BITS + 1);

    // Search result: {found, bit value, position counted from one}
    function automatic logic [CNT_W+1:0] find_live(
        input logic [MAX_BITS-1:0] w,
        input logic [CNT_W-1:0]    lim,
        input logic                live0,
        input logic                live1
    );
        logic             found;
        logic             bv;
        logic [CNT_W-1:0] pos;
        found = 1'b0;
        bv    = 1'b0;
        pos   = '0;
        for (int i = 0; i < MAX_BITS; i++)
        begin
            if ((CNT_W'(i) < lim) && (w[i] ? live1 : live0))
            begin
                found = 1'b1;
                bv    = w[i];
                pos   = CNT_W'(i + 1);
            end
        end
        return {found, bv, pos};
    endfunction

    // Bit of the word at a position counted from one
    function automatic logic bit_at(
        input logic [MAX_BITS-1:0] w,
        input logic [CNT_W-1:0]    pos
    );
        logic b;
        b = 1'b0;
        for (int i = 0; i < MAX_BITS; i++)
        begin
            if (CNT_W'(i + 1) == pos)
            begin
                b = w[i];
            end
        end
        return b;
    endfunction

    // Configuration registers
    logic [PULSE_W-1:0] pulse_unit_reg;
    logic [UNITS_W-1:0] one_high_reg;
    logic [UNITS_W-1:0] one_low_reg;
    logic [UNITS_W-1:0] zero_high_reg;
    logic [UNITS_W-1:0] zero_low_reg;
    logic [UNITS_W-1:0] sync_high_reg;
    logic [UNITS_W-1:0] sync_low_reg;
    logic               invert_reg;

    // Transmit state
    logic                active_reg, active_next;
    logic [MAX_BITS-1:0] word_reg, word_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic [CNT_W-1:0]    bits_left_reg, bits_left_next;
    logic [REP_W-1:0]    repeats_reg, repeats_next;
    logic [1:0]          phase_reg, phase_next;
    logic [TICKS_W-1:0]  ticks_reg, ticks_next;

    // Request fields
    logic                is_start;
    logic [MAX_BITS-1:0] in_word;
    logic [CNT_W-1:0]    in_len;
    logic [REP_W-1:0]    in_rep;
    logic                accept;
    logic                buf_ready;

    // Phase liveness
    logic pu_nz, oh_nz, ol_nz, zh_nz, zl_nz, sh_nz, sl_nz, live0, live1;
    logic cur_bit, cur_lo_nz;
    logic [CNT_W+1:0]    below_hit, top_hit;
    logic [MAX_BITS-1:0] top_word;
    logic [CNT_W-1:0]    top_len;

    // Next-state scratch
    logic               go_below, go_y, go_e, use_top, advance, new_bit, load_len;
    logic [REP_W-1:0]   rep_dec;
    logic [TICKS_W-1:0] ticks_dec;
    logic [UNITS_W-1:0] factor;
    logic [TICKS_W-1:0] phase_len;
    result_t            res;
    result_t            out_res;

    assign is_start = (s_axis_tuser == REQ_START);
    assign in_word  = MAX_BITS'(s_axis_tdata[CODE_W-1:0]);
    assign in_len   = ({1'b0, s_axis_tdata[CODE_W+CODE_LEN_W-1:CODE_W]} > 7'(MAX_BITS))
                      ? CNT_W'(MAX_BITS) : CNT_W'(s_axis_tdata[CODE_W+CODE_LEN_W-1:CODE_W]);
    assign in_rep   = s_axis_tdata[CODE_W+CODE_LEN_W+REP_W-1:CODE_W+CODE_LEN_W];
    assign s_axis_tready = buf_ready;
    assign accept   = s_axis_tvalid && buf_ready;
    assign cfg_ready = 1'b1;

    // Which phases have a nonzero length
    assign pu_nz = (pulse_unit_reg != '0);
    assign oh_nz = pu_nz && (one_high_reg != '0);
    assign ol_nz = pu_nz && (one_low_reg != '0);
    assign zh_nz = pu_nz && (zero_high_reg != '0);
    assign zl_nz = pu_nz && (zero_low_reg != '0);
    assign sh_nz = pu_nz && (sync_high_reg != '0);
    assign sl_nz = pu_nz && (sync_low_reg != '0);
    assign live1 = oh_nz || ol_nz;
    assign live0 = zh_nz || zl_nz;

    // Current bit and searches for the next live bit
    assign cur_bit   = bit_at(word_reg, bits_left_reg);
    assign cur_lo_nz = cur_bit ? ol_nz : zl_nz;
    assign below_hit = find_live(word_reg, bits_left_reg - CNT_W'(1), live0, live1);
    assign top_word  = is_start ? in_word : word_reg;
    assign top_len   = is_start ? in_len : len_reg;
    assign top_hit   = find_live(top_word, top_len, live0, live1);

    // Next state and result for one request
    always_comb
    begin
        active_next    = active_reg;
        word_next      = word_reg;
        len_next       = len_reg;
        bits_left_next = bits_left_reg;
        repeats_next   = repeats_reg;
        phase_next     = phase_reg;
        ticks_dec      = ticks_reg;
        new_bit        = cur_bit;
        go_below       = 1'b0;
        go_y           = 1'b0;
        go_e           = 1'b0;
        use_top        = 1'b0;
        advance        = 1'b0;
        load_len       = 1'b0;
        rep_dec        = (repeats_reg != '0) ? repeats_reg - REP_W'(1) : '0;
        res            = '0;
        res.line_level = invert_reg;

        if (is_start)
        begin
            if (active_reg)
            begin
                res.start_rejected = 1'b1;
                res.busy_res       = 1'b1;
                res.line_level     = ((phase_reg == PH_BIT_HIGH) || (phase_reg == PH_SYNC_HIGH))
                                     ^ invert_reg;
            end
            else
            begin
                word_next    = in_word;
                len_next     = in_len;
                repeats_next = in_rep;
                if (in_rep == '0)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    active_next = 1'b1;
                    use_top     = 1'b1;
                end
            end
        end
        else if (active_reg)
        begin
            res.busy_res   = 1'b1;
            res.line_level = ((phase_reg == PH_BIT_HIGH) || (phase_reg == PH_SYNC_HIGH))
                             ^ invert_reg;
            if (ticks_reg > TICKS_W'(1))
            begin
                ticks_dec = ticks_reg - TICKS_W'(1);
            end
            else
            begin
                advance = 1'b1;
                case (phase_reg)
                    PH_BIT_HIGH:
                    begin
                        if (cur_lo_nz)
                        begin
                            phase_next = PH_BIT_LOW;
                        end
                        else
                        begin
                            go_below = 1'b1;
                        end
                    end
                    PH_BIT_LOW:
                    begin
                        go_below = 1'b1;
                    end
                    PH_SYNC_HIGH:
                    begin
                        if (sl_nz)
                        begin
                            phase_next = PH_SYNC_LOW;
                        end
                        else
                        begin
                            go_e = 1'b1;
                        end
                    end
                    default:
                    begin
                        go_e = 1'b1;
                    end
                endcase
            end
        end

        // Next live bit below the current one
        if (go_below)
        begin
            if (below_hit[CNT_W+1])
            begin
                new_bit        = below_hit[CNT_W];
                bits_left_next = below_hit[CNT_W-1:0];
                phase_next     = (below_hit[CNT_W] ? oh_nz : zh_nz) ? PH_BIT_HIGH : PH_BIT_LOW;
            end
            else
            begin
                go_y = 1'b1;
            end
        end

        // Sync symbol after the word
        if (go_y)
        begin
            bits_left_next = '0;
            if (sh_nz)
            begin
                phase_next = PH_SYNC_HIGH;
            end
            else if (sl_nz)
            begin
                phase_next = PH_SYNC_LOW;
            end
            else
            begin
                go_e = 1'b1;
            end
        end

        // End of one repeat
        if (go_e)
        begin
            repeats_next = rep_dec;
            if (rep_dec == '0)
            begin
                active_next = 1'b0;
            end
            else
            begin
                use_top = 1'b1;
            end
        end

        // Start of a pass over the word; a dead pass goes to sync, or ends the transmission if sync is empty too
        if (use_top)
        begin
            if (top_hit[CNT_W+1])
            begin
                new_bit        = top_hit[CNT_W];
                bits_left_next = top_hit[CNT_W-1:0];
                phase_next     = (top_hit[CNT_W] ? oh_nz : zh_nz) ? PH_BIT_HIGH : PH_BIT_LOW;
            end
            else
            begin
                bits_left_next = '0;
                if (sh_nz)
                begin
                    phase_next = PH_SYNC_HIGH;
                end
                else if (sl_nz)
                begin
                    phase_next = PH_SYNC_LOW;
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
        end

        // Start taken at idle reports the first phase
        if (is_start && !active_reg)
        begin
            res.busy_res = active_next;
            if (active_next)
            begin
                res.line_level = ((phase_next == PH_BIT_HIGH) || (phase_next == PH_SYNC_HIGH))
                                 ^ invert_reg;
            end
        end

        if (advance)
        begin
            res.done_res = !active_next;
        end

        load_len = (advance || (is_start && !active_reg)) && active_next;
    end

    // Factor of the phase being entered, times the base unit
    always_comb
    begin
        case (phase_next)
            PH_BIT_HIGH:  factor = new_bit ? one_high_reg : zero_high_reg;
            PH_BIT_LOW:   factor = new_bit ? one_low_reg : zero_low_reg;
            PH_SYNC_HIGH: factor = sync_high_reg;
            default:      factor = sync_low_reg;
        endcase
    end

    assign phase_len = {8'b0, pulse_unit_reg} * {16'b0, factor};

    // Phase counter: reload on entering a phase, else count down
    assign ticks_next = load_len ? phase_len : ticks_dec;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_unit_reg <= 16'd350;
            one_high_reg   <= 8'd3;
            one_low_reg    <= 8'd1;
            zero_high_reg  <= 8'd1;
            zero_low_reg   <= 8'd3;
            sync_high_reg  <= 8'd1;
            sync_low_reg   <= 8'd31;
            invert_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PULSE_UNIT:      pulse_unit_reg <= cfg_data;
                REG_ONE_HIGH_UNITS:  one_high_reg   <= cfg_data[UNITS_W-1:0];
                REG_ONE_LOW_UNITS:   one_low_reg    <= cfg_data[UNITS_W-1:0];
                REG_ZERO_HIGH_UNITS: zero_high_reg  <= cfg_data[UNITS_W-1:0];
                REG_ZERO_LOW_UNITS:  zero_low_reg   <= cfg_data[UNITS_W-1:0];
                REG_SYNC_HIGH_UNITS: sync_high_reg  <= cfg_data[UNITS_W-1:0];
                REG_SYNC_LOW_UNITS:  sync_low_reg   <= cfg_data[UNITS_W-1:0];
                REG_INVERT_OUTPUT:   invert_reg     <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Transmit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            word_reg      <= '0;
            len_reg       <= '0;
            bits_left_reg <= '0;
            repeats_reg   <= '0;
            phase_reg     <= PH_BIT_HIGH;
            ticks_reg     <= '0;
        end
        else if (accept)
        begin
            active_reg    <= active_next;
            word_reg      <= word_next;
            len_reg       <= len_next;
            bits_left_reg <= bits_left_next;
            repeats_reg   <= repeats_next;
            phase_reg     <= phase_next;
            ticks_reg     <= ticks_next;
        end
    end

    // Result buffer
    ookpc_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_ready  (buf_ready),
        .in_data   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = {4'b0000, out_res};

    // A running transmission always has a phase with ticks and a repeat left
    a_active_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (ticks_reg != '0))
        else $error("active with empty phase counter");

    a_active_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (repeats_reg != '0))
        else $error("active with no repeat left");

    // Bit phases point inside the loaded word
    a_bit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && ((phase_reg == PH_BIT_HIGH) || (phase_reg == PH_BIT_LOW)))
        |-> ((bits_left_reg != '0) && (bits_left_reg <= len_reg)))
        else $error("bit phase outside the word");

    // Done ends a transmission and is reported as busy
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.done_res) |=> (!active_reg && $past(res.busy_res)))
        else $error("done without end of transmission");

endmodule

// ----- sv/ookpc_out_skid.sv -----
// Two-entry output buffer for the transmitter results.
// Keeps the upstream ready a register so the two sides are parted.
// Depends on ookpc_pkg.
module ookpc_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ookpc_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ookpc_pkg::result_t out_data
);
    import ookpc_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_data_reg;
    result_t skid_data_reg;
    logic    main_free;

    assign main_free = !main_valid_reg || out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // Occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= in_valid;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the OOK pulse code transmitter.
// Drives tick and start requests, predicts each result in the bench and checks it.
// Depends on ookpc_pkg and ook_pulse_code_transmitter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ookpc_pkg::*;

    localparam int MAX_BITS     = 32;
    localparam int SKIP_LIMIT   = 2 * MAX_BITS + 4;
    localparam int RANDOM_ITEMS = 1700;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{
        REG_PULSE_UNIT, REG_ONE_HIGH_UNITS, REG_ONE_LOW_UNITS, REG_ZERO_HIGH_UNITS,
        REG_ZERO_LOW_UNITS, REG_SYNC_HIGH_UNITS, REG_SYNC_LOW_UNITS, REG_INVERT_OUTPUT
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    // tdata: code_value[31:0], code_length[37:32], repeat_count[53:38], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // tuser: req_type
    logic                   s_axis_tuser = REQ_TICK;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: line_level[0], busy_res[1], done_res[2], start_rejected[3], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Shared bench state
    result_t line_due [$];
    int      mismatch_cnt = 0;
    int      items_sent = 0;
    int      cycle_cnt = 0;
    int      idle_pct = 0;
    int      hold_asked = 0;
    int      hold_served = 0;
    int      stall_left = 0;

    // Predicted configuration
    logic [PULSE_W-1:0] pulse_unit_r;
    logic [UNITS_W-1:0] one_hi, one_lo, zero_hi, zero_lo, sync_hi, sync_lo;
    logic               inv_line;

    // Predicted transmit state
    logic                  tx_active;
    logic [CODE_W-1:0]     word_sr;
    logic [CODE_LEN_W-1:0] bits_left;
    logic [CODE_LEN_W-1:0] saved_len;
    logic [CODE_W-1:0]     saved_word;
    logic [REP_W-1:0]      reps_left;
    logic [1:0]            phase;
    logic [TICKS_W-1:0]    ticks_left;

    ook_pulse_code_transmitter #(
        .MAX_BITS(MAX_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, line_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------

    function automatic void model_reset();
        pulse_unit_r = 16'd350;
        one_hi       = 8'd3;
        one_lo       = 8'd1;
        zero_hi      = 8'd1;
        zero_lo      = 8'd3;
        sync_hi      = 8'd1;
        sync_lo      = 8'd31;
        inv_line     = 1'b0;
        tx_active    = 1'b0;
        word_sr      = '0;
        bits_left    = '0;
        saved_len    = '0;
        saved_word   = '0;
        reps_left    = '0;
        phase        = PH_BIT_HIGH;
        ticks_left   = '0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PULSE_UNIT:      pulse_unit_r = val;
            REG_ONE_HIGH_UNITS:  one_hi = val[UNITS_W-1:0];
            REG_ONE_LOW_UNITS:   one_lo = val[UNITS_W-1:0];
            REG_ZERO_HIGH_UNITS: zero_hi = val[UNITS_W-1:0];
            REG_ZERO_LOW_UNITS:  zero_lo = val[UNITS_W-1:0];
            REG_SYNC_HIGH_UNITS: sync_hi = val[UNITS_W-1:0];
            REG_SYNC_LOW_UNITS:  sync_lo = val[UNITS_W-1:0];
            REG_INVERT_OUTPUT:   inv_line = val[0];
            default: ;
        endcase
    endfunction

    // Ticks of the current phase; the factor depends on the bit in front
    function automatic logic [TICKS_W-1:0] phase_span();
        logic [UNITS_W-1:0] f;
        case (phase)
            PH_BIT_HIGH:  f = word_sr[CODE_W-1] ? one_hi : zero_hi;
            PH_BIT_LOW:   f = word_sr[CODE_W-1] ? one_lo : zero_lo;
            PH_SYNC_HIGH: f = sync_hi;
            default:      f = sync_lo;
        endcase
        return TICKS_W'(pulse_unit_r) * TICKS_W'(f);
    endfunction

    function automatic void reload_word();
        bits_left = saved_len;
        word_sr   = (saved_len == 0) ? '0 : saved_word << (CODE_W - saved_len);
        phase     = (bits_left != 0) ? PH_BIT_HIGH : PH_SYNC_HIGH;
    endfunction

    function automatic void advance_phase();
        case (phase)
            PH_BIT_HIGH:
                phase = PH_BIT_LOW;
            PH_BIT_LOW:
            begin
                word_sr = word_sr << 1;
                if (bits_left != 0)
                    bits_left--;
                phase = (bits_left != 0) ? PH_BIT_HIGH : PH_SYNC_HIGH;
            end
            PH_SYNC_HIGH:
                phase = PH_SYNC_LOW;
            default:
            begin
                if (reps_left != 0)
                    reps_left--;
                if (reps_left != 0)
                    reload_word();
                else
                    tx_active = 1'b0;
            end
        endcase
    endfunction

    // Step over empty phases; a word with no timed phase at all ends the run
    function automatic void skip_empty();
        logic [TICKS_W-1:0] span;
        for (int n = 0; n < SKIP_LIMIT; n++)
        begin
            if (!tx_active)
                return;
            span = phase_span();
            if (span != 0)
            begin
                ticks_left = span;
                return;
            end
            advance_phase();
        end
        tx_active = 1'b0;
    endfunction

    function automatic logic line_now();
        return ((phase == PH_BIT_HIGH) || (phase == PH_SYNC_HIGH)) ^ inv_line;
    endfunction

    function automatic result_t predict_line(logic kind, logic [CODE_W-1:0] code,
                                             logic [CODE_LEN_W-1:0] len,
                                             logic [REP_W-1:0] rep);
        result_t r;
        r = '0;
        r.line_level = inv_line;
        if (kind == REQ_START)
        begin
            if (tx_active)
            begin
                r.start_rejected = 1'b1;
                r.busy_res       = 1'b1;
                r.line_level     = line_now();
            end
            else
            begin
                saved_len  = (len > MAX_BITS) ? CODE_LEN_W'(MAX_BITS) : len;
                saved_word = code;
                reps_left  = rep;
                if (rep != 0)
                begin
                    tx_active = 1'b1;
                    reload_word();
                    skip_empty();
                end
                if (tx_active)
                begin
                    r.busy_res   = 1'b1;
                    r.line_level = line_now();
                end
            end
        end
        else if (tx_active)
        begin
            r.busy_res   = 1'b1;
            r.line_level = line_now();
            if (ticks_left != 0)
                ticks_left--;
            if (ticks_left == 0)
            begin
                advance_phase();
                skip_empty();
                if (!tx_active)
                    r.done_res = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Pacing, drivers and result check
    // ------------------------------------------------------------------

    // Mostly short pauses, now and then a long one
    function automatic int pause_len();
        return ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    function automatic int pick_pause();
        if (idle_pct == 0 || $urandom_range(99) >= idle_pct)
            return 0;
        return pause_len();
    endfunction

    // Result side ready: random stalls plus the long hold on request
    always @(posedge clk)
    begin
        if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            stall_left  = LONG_HOLD;
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if (pick_pause() > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = pause_len() - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[3:0];
            if (line_due.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: lvl=%b busy=%b done=%b rej=%b",
                             $realtime, got.line_level, got.busy_res, got.done_res,
                             got.start_rejected);
            end
            else
            begin
                want = line_due.pop_front();
                if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
                    got.done_res !== want.done_res ||
                    got.start_rejected !== want.start_rejected)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: mismatch lvl/busy/done/rej expected %b%b%b%b got %b%b%b%b",
                                 $realtime, want.line_level, want.busy_res, want.done_res,
                                 want.start_rejected, got.line_level, got.busy_res,
                                 got.done_res, got.start_rejected);
                end
            end
        end
    end

    // Offer one request, wait for it to be taken, then predict its result
    task automatic send_req(input logic kind, input logic [CODE_W-1:0] code,
                            input logic [CODE_LEN_W-1:0] len, input logic [REP_W-1:0] rep);
        int gap;
        result_t r;
        gap = pick_pause();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, rep, len, code};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = predict_line(kind, code, len, rep);
        line_due.push_back(r);
        if (!r.start_rejected)
            items_sent++;
    endtask

    // Ticks carry junk in the unused fields
    task automatic send_tick();
        send_req(REQ_TICK, $urandom, CODE_LEN_W'($urandom), REP_W'($urandom));
    endtask

    // Drop valid, let every expected result come back, then settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (line_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Tick the current transmission out and go idle
    task automatic quiesce();
        while (tx_active)
            send_tick();
        wait_drained();
    endtask

    // Let traffic drain, then write all registers back to back; the block must be idle
    task automatic set_config(input logic [PULSE_W-1:0] pulse,
                              input logic [UNITS_W-1:0] oh, ol, zh, zl, sh, sl,
                              input logic inv);
        logic [CFG_DATA_W-1:0] vals [8];
        wait_drained();
        vals = '{pulse, {8'($urandom), oh}, {8'($urandom), ol}, {8'($urandom), zh},
                 {8'($urandom), zl}, {8'($urandom), sh}, {8'($urandom), sl},
                 {15'($urandom), inv}};
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            apply_reg(REG_ORDER[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: idle ticks and starts that send nothing
    task automatic test_idle_after_reset();
        idle_pct = 0;
        send_req(REQ_TICK, '1, '1, '1);
        send_req(REQ_TICK, '0, '0, '0);
        send_req(REQ_START, '1, '1, '0);
        send_req(REQ_START, '0, '0, '0);
        send_tick();
        wait_drained();
    endtask

    // Every phase empty: even the largest repeat count sends nothing; so does a zero repeat count
    task automatic test_empty_phases();
        set_config(16'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_req(REQ_START, '1, CODE_LEN_W'(MAX_BITS), '1);
        send_tick();
        send_req(REQ_START, '0, '0, REP_W'(1));
        set_config('1, '1, '1, '1, '1, '1, '1, 1'b1);
        send_req(REQ_START, '1, '1, '0);
        send_tick();
        set_config('1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_req(REQ_START, '1, '1, '1);
        send_tick();
        wait_drained();
    endtask

    // Short words, a start while busy, sync-only and saturated lengths
    task automatic test_short_words();
        set_config(16'd1, 8'd2, 8'd1, 8'd1, 8'd2, 8'd1, 8'd3, 1'b0);
        send_req(REQ_START, 32'h5, CODE_LEN_W'(3), REP_W'(2));
        send_tick();
        send_tick();
        send_req(REQ_START, '1, '1, '1);
        quiesce();
        send_req(REQ_START, $urandom, '0, REP_W'(1));
        quiesce();
        send_req(REQ_START, '1, '1, REP_W'(1));
        quiesce();
        send_req(REQ_START, '0, CODE_LEN_W'(MAX_BITS), REP_W'(1));
        quiesce();
    endtask

    // Inverted line with some empty phases inside the word
    task automatic test_inverted_line();
        set_config(16'd2, 8'd1, 8'd0, 8'd0, 8'd1, 8'd0, 8'd2, 1'b1);
        send_req(REQ_START, 32'hA5, CODE_LEN_W'(8), REP_W'(3));
        quiesce();
        send_tick();
        send_tick();
        wait_drained();
    endtask

    // Long phases: the widest factor, then a pulse unit past eight bits
    task automatic test_long_phases();
        set_config(16'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
        send_req(REQ_START, $urandom, '0, REP_W'(1));
        quiesce();
        set_config(16'd257, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 1'b1);
        send_req(REQ_START, $urandom, '0, REP_W'(1));
        quiesce();
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_hold();
        set_config(16'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 1'b0);
        idle_pct = 0;
        send_req(REQ_START, $urandom, CODE_LEN_W'(16), REP_W'(4));
        hold_asked++;
        repeat (40) send_tick();
        quiesce();
    endtask

    // Random settings, each followed by a few transmissions with random content
    task automatic test_random_traffic();
        int target;
        int r;
        logic [PULSE_W-1:0] pulse;
        logic [CODE_LEN_W-1:0] len;
        logic [REP_W-1:0] rep;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            quiesce();
            r = $urandom_range(99);
            pulse = (r < 70) ? 16'd1 : (r < 90) ? 16'd2 : PULSE_W'($urandom_range(3, 6));
            set_config(pulse, UNITS_W'($urandom_range(2)), UNITS_W'($urandom_range(2)),
                       UNITS_W'($urandom_range(2)), UNITS_W'($urandom_range(2)),
                       UNITS_W'($urandom_range(2)), UNITS_W'($urandom_range(3)),
                       1'($urandom_range(1)));
            case ($urandom_range(3))
                0: idle_pct = 0;
                1: idle_pct = 10;
                2: idle_pct = 30;
                default: idle_pct = 60;
            endcase
            repeat ($urandom_range(2, 5))
            begin
                r = $urandom_range(99);
                len = (r < 70) ? CODE_LEN_W'($urandom_range(0, 12)) :
                      (r < 90) ? CODE_LEN_W'($urandom_range(13, 32)) :
                                 CODE_LEN_W'($urandom_range(33, 63));
                rep = ($urandom_range(9) == 0) ? '0 : REP_W'($urandom_range(1, 3));
                send_req(REQ_START, $urandom, len, rep);
                while (tx_active)
                begin
                    if ($urandom_range(99) < 4)
                        send_req(REQ_START, $urandom, CODE_LEN_W'($urandom),
                                 REP_W'($urandom));
                    else
                        send_tick();
                end
                repeat ($urandom_range(2)) send_tick();
            end
        end
        quiesce();
    endtask

    // Test sequence
    initial
    begin
        model_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_after_reset();
        test_empty_phases();
        test_short_words();
        test_inverted_line();
        test_long_phases();
        test_output_hold();
        test_random_traffic();
        wait_drained();
        if (mismatch_cnt == 0 && line_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
